FILE: sv/tnae_pkg.sv
// Package for the tile neighbor autotile encoder.
// Holds sizes, kind and class codes, the result struct and the microcode ROM.
// No dependencies.
package tnae_pkg;

  localparam int MAX_MAP_WIDTH  = 128;
  localparam int MAX_MAP_HEIGHT = 128;
  localparam int ROW_W     = $clog2(MAX_MAP_HEIGHT);
  localparam int COL_W     = $clog2(MAX_MAP_WIDTH);
  localparam int MAP_AW    = ROW_W + COL_W;
  localparam int MAP_DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int SIZE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int CLASS_W   = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 8'd98;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 8'd66;
  localparam logic [SIZE_W-1:0] SIZE_MIN     = 8'd3;
  localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_MAP_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_MAP_HEIGHT);

  // Configuration register indexes.
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // Commands carried on tuser.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_GRASS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TREE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WALL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROCK  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_WATER = 3'd6;

  localparam logic [CLASS_W-1:0] CLASS_BORDER = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_WATER  = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_ROCK   = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_TREE   = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_WALL   = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_GRASS  = 3'd5;
  localparam logic [CLASS_W-1:0] CLASS_DIRT   = 3'd6;
  localparam logic [CLASS_W-1:0] CLASS_PLAIN  = 3'd7;

  typedef struct packed {
    logic               top_valid;
    logic [5:0]         top_mask;
    logic [7:0]         neighbor_mask;
    logic [CLASS_W-1:0] tile_class;
  } result_t;

  // Which side of the center a neighbor lies on.
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nb_dir_t;

  typedef enum logic [3:0] {
    ST_FETCH = 4'd0,
    ST_WRITE = 4'd1,
    ST_RD0   = 4'd2,
    ST_RD1   = 4'd3,
    ST_RD2   = 4'd4,
    ST_RD3   = 4'd5,
    ST_RD4   = 4'd6,
    ST_RD5   = 4'd7,
    ST_RD6   = 4'd8,
    ST_RD7   = 4'd9,
    ST_ACC   = 4'd10,
    ST_DEC   = 4'd11
  } step_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_DISPATCH = 2'd1,
    JMP_FETCH    = 2'd2,
    JMP_WAIT_OUT = 2'd3
  } jmp_t;

  typedef struct packed {
    logic       fetch;
    logic       rd;
    logic       acc;
    logic       wr;
    logic       dec;
    logic [2:0] nb;
    jmp_t       jmp;
  } ucode_t;

  // Neighbor order: bottom-right, bottom, bottom-left, right, left,
  // top-right, top, top-left. The first one read lands in the top mask bit.
  function automatic nb_dir_t nb_dir(input logic [2:0] k);
    nb_dir_t d;
    d = '0;
    case (k)
      3'd0: d = '{up: 1'b0, dn: 1'b1, lf: 1'b0, rt: 1'b1};
      3'd1: d = '{up: 1'b0, dn: 1'b1, lf: 1'b0, rt: 1'b0};
      3'd2: d = '{up: 1'b0, dn: 1'b1, lf: 1'b1, rt: 1'b0};
      3'd3: d = '{up: 1'b0, dn: 1'b0, lf: 1'b0, rt: 1'b1};
      3'd4: d = '{up: 1'b0, dn: 1'b0, lf: 1'b1, rt: 1'b0};
      3'd5: d = '{up: 1'b1, dn: 1'b0, lf: 1'b0, rt: 1'b1};
      3'd6: d = '{up: 1'b1, dn: 1'b0, lf: 1'b0, rt: 1'b0};
      3'd7: d = '{up: 1'b1, dn: 1'b0, lf: 1'b1, rt: 1'b0};
      default: d = '0;
    endcase
    return d;
  endfunction

  // Microcode ROM: one control word per step.
  function automatic ucode_t ucode(input step_t s);
    ucode_t u;
    u = '{fetch: 1'b0, rd: 1'b0, acc: 1'b0, wr: 1'b0, dec: 1'b0,
          nb: 3'd0, jmp: JMP_NEXT};
    case (s)
      ST_FETCH: begin
        u.fetch = 1'b1;
        u.jmp   = JMP_DISPATCH;
      end
      ST_WRITE: begin
        u.wr  = 1'b1;
        u.jmp = JMP_FETCH;
      end
      ST_RD0: begin
        u.rd = 1'b1;
        u.nb = 3'd0;
      end
      ST_RD1: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd1;
      end
      ST_RD2: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd2;
      end
      ST_RD3: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd3;
      end
      ST_RD4: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd4;
      end
      ST_RD5: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd5;
      end
      ST_RD6: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd6;
      end
      ST_RD7: begin
        u.rd  = 1'b1;
        u.acc = 1'b1;
        u.nb  = 3'd7;
      end
      ST_ACC: begin
        u.acc = 1'b1;
      end
      ST_DEC: begin
        u.dec = 1'b1;
        u.jmp = JMP_WAIT_OUT;
      end
      default: begin
        u.jmp = JMP_FETCH;
      end
    endcase
    return u;
  endfunction

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) r = SIZE_MIN;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

FILE: sv/tnae_classify.sv
// Result formatter for the autotile encoder: turns the gathered match and
// dirt bits into the image class and masks. Depends on tnae_pkg.
module tnae_classify (
  input  logic [tnae_pkg::KIND_W-1:0] kind,
  input  logic                        interior,
  input  logic                        up_ok,
  input  logic [7:0]                  match,
  input  logic [7:0]                  dirt,
  output tnae_pkg::result_t           result
);
  import tnae_pkg::*;

  always_comb begin
    result = '0;
    if (interior) begin
      if (kind == KIND_WATER || kind == KIND_ROCK) begin
        result.tile_class    = (kind == KIND_WATER) ? CLASS_WATER : CLASS_ROCK;
        result.neighbor_mask = match;
      end else if (kind == KIND_TREE) begin
        result.tile_class    = CLASS_TREE;
        result.neighbor_mask = {2'b00, match[7:5], match[4], 1'b1, match[3]};
        // A tree top is drawn when no tree sits directly above and the cell above is not in the top row.
        if (!match[1] && up_ok) begin
          result.top_valid = 1'b1;
          result.top_mask  = {match[4], 1'b1, match[3], match[2:0]};
        end
      end else if (kind == KIND_WALL) begin
        result.tile_class    = CLASS_WALL;
        result.neighbor_mask = {4'b0000, match[3], match[6], match[4], match[1]};
      end else if (kind == KIND_GRASS) begin
        if (dirt == 8'd0) begin
          result.tile_class = CLASS_GRASS;
        end else begin
          result.tile_class    = CLASS_DIRT;
          result.neighbor_mask = dirt;
        end
      end else begin
        result.tile_class = CLASS_PLAIN;
      end
    end
  end

endmodule

FILE: sv/tile_neighbor_autotile_encoder.sv
// Channel | Bits | Contents (lowest bit first)
// s_*     | tdata 24, tuser 1 | row[6:0], col[13:7], tile_kind[16:14]; tuser command
// m_*     | tdata 24 | tile_class[2:0], neighbor_mask[10:3], top_mask[16:11],
//         |          | top_valid[17]
// cfg_*   | index 1, data 8 | 0 map_width, 1 map_height
//
// A write runs the fetch step and a write step; an encode of an interior cell runs the
// fetch step, eight reads of the single-port tile memory, one drain step and a decision
// step; an encode on the border runs the fetch and decision steps. The sequencer holds
// one item at a time. After reset a clearing pass writes grass into all 16384 cells,
// one a cycle; no item is accepted until the pass ends. A stalled result holds the
// sequencer in its decision step until the result is taken.
module tile_neighbor_autotile_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row, col, tile_kind
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tile_class, neighbor_mask, top_mask, top_valid
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import tnae_pkg::*;

  logic [SIZE_W-1:0] map_width;
  logic [SIZE_W-1:0] map_height;

  step_t  pc, pc_next;
  ucode_t uc;

  logic              clr_active;
  logic [MAP_AW-1:0] clr_addr;

  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [KIND_W-1:0] kind_q;
  logic              interior_q;

  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [KIND_W-1:0] in_kind;
  logic              in_interior;
  logic              in_accept;

  logic              up_ok, dn_ok, lf_ok, rt_ok;
  nb_dir_t           dir;
  logic              nb_ok, nb_ok_q;
  logic [ROW_W-1:0]  nb_row;
  logic [COL_W-1:0]  nb_col;

  logic [MAP_AW-1:0] mem_addr;
  logic              mem_we;
  logic [KIND_W-1:0] mem_wdata;
  logic [KIND_W-1:0] rd_data;
  logic [KIND_W-1:0] tile_mem [MAP_DEPTH];

  logic [7:0] match;
  logic [7:0] dirt;
  logic       out_free;
  result_t    result;

  assign in_row  = s_tdata[ROW_W-1:0];
  assign in_col  = s_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_kind = s_tdata[MAP_AW+KIND_W-1:MAP_AW];

  assign in_interior = (in_row != '0) && (in_col != '0) &&
                       ({1'b0, in_row} + 8'd1 < map_height) &&
                       ({1'b0, in_col} + 8'd1 < map_width);

  assign uc        = ucode(pc);
  assign s_tready  = uc.fetch && !clr_active;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Configuration, kept already saturated to the legal size range.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= WIDTH_RESET;
      map_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAP_WIDTH) map_width <= sat_size(cfg_data, WIDTH_MAX);
      if (cfg_index == REG_MAP_HEIGHT) map_height <= sat_size(cfg_data, HEIGHT_MAX);
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) pc <= ST_FETCH;
    else     pc <= pc_next;
  end

  always_comb begin
    pc_next = pc;
    case (uc.jmp)
      JMP_NEXT: pc_next = step_t'(pc + 4'd1);
      JMP_DISPATCH: begin
        if (in_accept) begin
          if (s_tuser == CMD_WRITE) pc_next = ST_WRITE;
          else if (in_interior)     pc_next = ST_RD0;
          else                      pc_next = ST_DEC;
        end
      end
      JMP_FETCH:    pc_next = ST_FETCH;
      JMP_WAIT_OUT: pc_next = out_free ? ST_FETCH : ST_DEC;
      default:      pc_next = ST_FETCH;
    endcase
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      row_q      <= in_row;
      col_q      <= in_col;
      kind_q     <= in_kind;
      interior_q <= in_interior;
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clr_active <= 1'b0;
    end
  end

  // Neighbor addressing. For an interior center every neighbor is in range.
  assign up_ok = row_q > 7'd1;
  assign lf_ok = col_q > 7'd1;
  assign dn_ok = ({1'b0, row_q} + 8'd2 < map_height);
  assign rt_ok = ({1'b0, col_q} + 8'd2 < map_width);

  assign dir    = nb_dir(uc.nb);
  assign nb_ok  = (!dir.up || up_ok) && (!dir.dn || dn_ok) &&
                  (!dir.lf || lf_ok) && (!dir.rt || rt_ok);
  assign nb_row = dir.up ? row_q - 1'b1 : (dir.dn ? row_q + 1'b1 : row_q);
  assign nb_col = dir.lf ? col_q - 1'b1 : (dir.rt ? col_q + 1'b1 : col_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = kind_q;
    mem_addr  = {nb_row, nb_col};
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_wdata = KIND_GRASS;
      mem_addr  = clr_addr;
    end else if (uc.wr) begin
      mem_we   = interior_q;
      mem_addr = {row_q, col_q};
    end
  end

  // Single-port tile memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) tile_mem[mem_addr] <= mem_wdata;
    rd_data <= tile_mem[mem_addr];
  end

  // Read data arrives in the step after its read was issued.
  always_ff @(posedge clk) begin
    if (uc.rd) nb_ok_q <= nb_ok;
    if (uc.acc) begin
      match <= {match[6:0], nb_ok_q && (rd_data == kind_q)};
      dirt  <= {dirt[6:0], !(nb_ok_q && (rd_data == KIND_GRASS ||
                                         rd_data == KIND_WALL ||
                                         rd_data == KIND_TREE))};
    end
  end

  tnae_classify u_classify (
    .kind     (kind_q),
    .interior (interior_q),
    .up_ok    (up_ok),
    .match    (match),
    .dirt     (dirt),
    .result   (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uc.dec && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.dec && out_free) m_tdata <= {6'd0, result};
  end

endmodule

FILE: sv/tnae_checker.sv
// Port-level checks for the autotile encoder, bound to the top level.
// Depends on tnae_pkg and tile_neighbor_autotile_encoder.
module tnae_assert (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import tnae_pkg::*;

  // The clearing pass keeps the input closed right after reset.
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // One item at a time: an accepted item closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready in the cycle after an accepted item");

  // A write item never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_WRITE && !m_tvalid |=> !m_tvalid)
    else $error("result after a write item");

  // Border results carry no mask bits, and tree tops come only with trees.
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == CLASS_BORDER |-> m_tdata[17:3] == '0)
    else $error("border result with mask bits");

  a_top_tree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> m_tdata[2:0] == CLASS_TREE)
    else $error("tree top on a result that is not a tree");

endmodule

bind tile_neighbor_autotile_encoder tnae_assert u_tnae_assert (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
